// File: design/fmprc_pkg.sv
package fmprc_pkg;

  // Table size and derived index width.
  localparam int NUM_RULES = 16;
  localparam int IDX_W     = (NUM_RULES > 1) ? $clog2(NUM_RULES) : 1;
  localparam int SLOT_W    = 4;
  localparam int CMP_W     = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
  localparam int CNT_W     = 32;
  localparam int ADDR_W    = 32;
  localparam int PORT_W    = 16;

  // Request operation codes.
  localparam logic [1:0] OP_CLASSIFY   = 2'd0;
  localparam logic [1:0] OP_WRITE_RULE = 2'd1;
  localparam logic [1:0] OP_SET_ENABLE = 2'd2;

  // Protocol code that matches every packet protocol.
  localparam logic [1:0] PROTO_ANY = 2'd0;

  // One stored rule.
  typedef struct packed {
    logic [ADDR_W-1:0] src_addr;
    logic [ADDR_W-1:0] dst_addr;
    logic [ADDR_W-1:0] src_pmask;
    logic [ADDR_W-1:0] dst_pmask;
    logic [PORT_W-1:0] port_lo;
    logic [PORT_W-1:0] port_hi;
    logic              enable;
    logic              dir;
    logic [1:0]        proto;
    logic              deny;
  } rule_t;

  // A request as it travels down the chain, with its running verdict.
  typedef struct packed {
    logic [1:0]        op;
    logic [SLOT_W-1:0] rule_index;
    logic              dir;
    logic [1:0]        proto;
    logic [ADDR_W-1:0] src_addr;
    logic [ADDR_W-1:0] dst_addr;
    logic [ADDR_W-1:0] src_pmask;
    logic [ADDR_W-1:0] dst_pmask;
    logic [PORT_W-1:0] port_a;
    logic [PORT_W-1:0] port_b;
    logic              deny;
    logic              enable;
    logic              hit;
    logic [IDX_W-1:0]  hit_idx;
    logic              hit_deny;
  } token_t;

  // A zero rule address is a wildcard; otherwise compare under the mask.
  function automatic logic addr_match(input logic [ADDR_W-1:0] pkt,
                                      input logic [ADDR_W-1:0] rule,
                                      input logic [ADDR_W-1:0] mask);
    addr_match = (rule == '0) || ((pkt & mask) == (rule & mask));
  endfunction

endpackage

// File: design/first_match_packet_rule_classifier_top.sv
// First-match packet rule classifier.
// Input channel (in_*): one request per handshake, accepted at a rising edge
// with in_valid high and in_stall low. Operation classify checks a packet,
// write rule replaces a whole slot, and set enable changes only the enable bit.
// Output channel (out_*): exactly one result per request, taken at an edge
// with out_valid high and out_stall low. Writes report no hit and deny low.
// The rules sit in a chain of NUM_RULES cells, one rule per cell, and a
// request moves one cell per cycle, so the lowest matching slot is the one
// that marks the verdict first. One request is in the chain at a time, so a
// new request is accepted only once the previous result is registered.
// A result waiting under out_stall does not block acceptance of the next
// request, whose result then lands in a spare register, but a further
// request waits until the waiting result is taken.
// Synchronous reset clears every rule (all disabled) and all three counters,
// and empties the chain and the output registers.
module first_match_packet_rule_classifier_top
  import fmprc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_operation,
  input  logic [SLOT_W-1:0] in_rule_index,
  input  logic              in_direction,
  input  logic [1:0]        in_protocol,
  input  logic [ADDR_W-1:0] in_src_address,
  input  logic [ADDR_W-1:0] in_dst_address,
  input  logic [ADDR_W-1:0] in_src_prefix_mask,
  input  logic [ADDR_W-1:0] in_dst_prefix_mask,
  input  logic [PORT_W-1:0] in_port_a,
  input  logic [PORT_W-1:0] in_port_b,
  input  logic              in_deny_action,
  input  logic              in_enable_bit,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_denied,
  output logic              out_rule_hit,
  output logic [SLOT_W-1:0] out_hit_index,
  output logic [CNT_W-1:0]  out_classified_count,
  output logic [CNT_W-1:0]  out_allowed_count,
  output logic [CNT_W-1:0]  out_denied_count
);

  // One result as it leaves the block, counters included.
  typedef struct packed {
    logic              denied;
    logic              hit;
    logic [SLOT_W-1:0] index;
    logic [CNT_W-1:0]  classified;
    logic [CNT_W-1:0]  allowed;
    logic [CNT_W-1:0]  refused;
  } result_t;

  logic   busy_r;
  logic   out_valid_r;
  logic   spill_valid_r;
  logic   in_accept;
  logic   out_take;
  logic   chain_done;
  token_t tok_in;
  token_t tok_last;
  logic   vld [NUM_RULES+1];
  token_t tok [NUM_RULES+1];

  logic [CNT_W-1:0] cls_cnt_r, cls_cnt_nxt;
  logic [CNT_W-1:0] alw_cnt_r, alw_cnt_nxt;
  logic [CNT_W-1:0] dny_cnt_r, dny_cnt_nxt;
  result_t          res_done;
  result_t          out_res_r;
  result_t          spill_res_r;

  // Accept only with the chain empty and the spare result register free.
  assign in_stall  = busy_r || spill_valid_r;
  assign in_accept = in_valid && !in_stall;
  assign out_take  = out_valid_r && !out_stall;

  // Build the request entering the first cell.
  always_comb begin
    tok_in.op         = in_operation;
    tok_in.rule_index = in_rule_index;
    tok_in.dir        = in_direction;
    tok_in.proto      = in_protocol;
    tok_in.src_addr   = in_src_address;
    tok_in.dst_addr   = in_dst_address;
    tok_in.src_pmask  = in_src_prefix_mask;
    tok_in.dst_pmask  = in_dst_prefix_mask;
    tok_in.port_a     = in_port_a;
    tok_in.port_b     = in_port_b;
    tok_in.deny       = in_deny_action;
    tok_in.enable     = in_enable_bit;
    tok_in.hit        = 1'b0;
    tok_in.hit_idx    = '0;
    tok_in.hit_deny   = 1'b0;
  end

  assign vld[0] = in_accept;
  assign tok[0] = tok_in;

  // The rule chain, slot 0 first.
  for (genvar k = 0; k < NUM_RULES; k++) begin : g_cell
    fmprc_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cell_idx    (IDX_W'(k)),
      .tok_valid_i (vld[k]),
      .tok_i       (tok[k]),
      .tok_valid_o (vld[k+1]),
      .tok_o       (tok[k+1])
    );
  end

  assign chain_done = vld[NUM_RULES];
  assign tok_last   = tok[NUM_RULES];

  // Counter updates for a finished classify request.
  always_comb begin
    cls_cnt_nxt = cls_cnt_r;
    alw_cnt_nxt = alw_cnt_r;
    dny_cnt_nxt = dny_cnt_r;
    if (chain_done && (tok_last.op == OP_CLASSIFY)) begin
      cls_cnt_nxt = cls_cnt_r + 1'b1;
      if (tok_last.hit_deny) begin
        dny_cnt_nxt = dny_cnt_r + 1'b1;
      end else begin
        alw_cnt_nxt = alw_cnt_r + 1'b1;
      end
    end
  end

  // The finished result carries the counters after its own update.
  always_comb begin
    res_done.denied     = tok_last.hit_deny;
    res_done.hit        = tok_last.hit;
    res_done.index      = SLOT_W'(tok_last.hit_idx);
    res_done.classified = cls_cnt_nxt;
    res_done.allowed    = alw_cnt_nxt;
    res_done.refused    = dny_cnt_nxt;
  end

  // Control state and counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r        <= 1'b0;
      out_valid_r   <= 1'b0;
      spill_valid_r <= 1'b0;
      cls_cnt_r     <= '0;
      alw_cnt_r     <= '0;
      dny_cnt_r     <= '0;
    end else begin
      if (in_accept) begin
        busy_r <= 1'b1;
      end else if (chain_done) begin
        busy_r <= 1'b0;
      end
      if (chain_done) begin
        if (!out_valid_r || out_take) begin
          out_valid_r <= 1'b1;
        end else begin
          spill_valid_r <= 1'b1;
        end
      end else if (out_take) begin
        if (spill_valid_r) begin
          spill_valid_r <= 1'b0;
        end else begin
          out_valid_r <= 1'b0;
        end
      end
      cls_cnt_r <= cls_cnt_nxt;
      alw_cnt_r <= alw_cnt_nxt;
      dny_cnt_r <= dny_cnt_nxt;
    end
  end

  // Result payload registers: the output register and its spare.
  always_ff @(posedge clk) begin
    if (chain_done) begin
      if (!out_valid_r || out_take) begin
        out_res_r <= res_done;
      end else begin
        spill_res_r <= res_done;
      end
    end else if (out_take && spill_valid_r) begin
      out_res_r <= spill_res_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_denied           = out_res_r.denied;
  assign out_rule_hit         = out_res_r.hit;
  assign out_hit_index        = out_res_r.index;
  assign out_classified_count = out_res_r.classified;
  assign out_allowed_count    = out_res_r.allowed;
  assign out_denied_count     = out_res_r.refused;

endmodule

// File: design/fmprc_cell.sv
module fmprc_cell
  import fmprc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IDX_W-1:0] cell_idx,
  input  logic             tok_valid_i,
  input  token_t           tok_i,
  output logic             tok_valid_o,
  output token_t           tok_o
);

  rule_t            rule_r, rule_nxt;
  token_t           tok_r, tok_nxt;
  logic             tok_valid_r;
  logic             slot_sel;
  logic [PORT_W-1:0] pkt_port;
  logic             match;

  // This cell owns the slot named by a write request.
  assign slot_sel = (CMP_W'(tok_i.rule_index) == CMP_W'(cell_idx));

  // Compare the passing packet against the stored rule.
  always_comb begin
    pkt_port = tok_i.dir ? tok_i.port_b : tok_i.port_a;
    match = rule_r.enable
         && (rule_r.dir == tok_i.dir)
         && ((rule_r.proto == PROTO_ANY) || (rule_r.proto == tok_i.proto))
         && addr_match(tok_i.src_addr, rule_r.src_addr, rule_r.src_pmask)
         && addr_match(tok_i.dst_addr, rule_r.dst_addr, rule_r.dst_pmask)
         && (pkt_port >= rule_r.port_lo)
         && (pkt_port <= rule_r.port_hi);
  end

  // Update the rule on a write or a set enable, or the verdict on a classify.
  always_comb begin
    rule_nxt = rule_r;
    tok_nxt  = tok_i;
    if (tok_valid_i) begin
      case (tok_i.op)
        OP_CLASSIFY: begin
          if (!tok_i.hit && match) begin
            tok_nxt.hit      = 1'b1;
            tok_nxt.hit_idx  = cell_idx;
            tok_nxt.hit_deny = rule_r.deny;
          end
        end
        OP_WRITE_RULE: begin
          if (slot_sel) begin
            rule_nxt.src_addr  = tok_i.src_addr;
            rule_nxt.dst_addr  = tok_i.dst_addr;
            rule_nxt.src_pmask = tok_i.src_pmask;
            rule_nxt.dst_pmask = tok_i.dst_pmask;
            rule_nxt.port_lo   = tok_i.port_a;
            rule_nxt.port_hi   = tok_i.port_b;
            rule_nxt.enable    = tok_i.enable;
            rule_nxt.dir       = tok_i.dir;
            rule_nxt.proto     = tok_i.proto;
            rule_nxt.deny      = tok_i.deny;
          end
        end
        OP_SET_ENABLE: begin
          if (slot_sel) begin
            rule_nxt.enable = tok_i.enable;
          end
        end
        default: begin
          rule_nxt = rule_r;
        end
      endcase
    end
  end

  // Rule storage and the hand-off register to the next cell.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rule_r      <= '0;
      tok_valid_r <= 1'b0;
    end else begin
      rule_r      <= rule_nxt;
      tok_valid_r <= tok_valid_i;
    end
  end

  always_ff @(posedge clk) begin
    tok_r <= tok_nxt;
  end

  assign tok_valid_o = tok_valid_r;
  assign tok_o       = tok_r;

endmodule

// File: sim/first_match_packet_rule_classifier_top_test.sv
module first_match_packet_rule_classifier_top_test;
  import fmprc_pkg::*;

  // Operation code 3 has no meaning to the block and must change nothing.
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_REQUESTS = 1200;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_CYCLES = 2 * (NUM_RULES + 2) + 4;

  typedef struct packed {
    logic [1:0]        op;
    logic [SLOT_W-1:0] idx;
    logic              dir;
    logic [1:0]        proto;
    logic [ADDR_W-1:0] src;
    logic [ADDR_W-1:0] dst;
    logic [ADDR_W-1:0] smask;
    logic [ADDR_W-1:0] dmask;
    logic [PORT_W-1:0] pa;
    logic [PORT_W-1:0] pb;
    logic              deny;
    logic              en;
  } request_t;

  typedef struct packed {
    logic              denied;
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic [CNT_W-1:0]  classified;
    logic [CNT_W-1:0]  allowed;
    logic [CNT_W-1:0]  refused;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic out_stall = 1'b0;
  request_t cur_req = '0;
  logic in_stall;
  logic out_valid;
  logic out_denied;
  logic out_rule_hit;
  logic [SLOT_W-1:0] out_hit_index;
  logic [CNT_W-1:0] out_classified_count;
  logic [CNT_W-1:0] out_allowed_count;
  logic [CNT_W-1:0] out_denied_count;

  first_match_packet_rule_classifier_top dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_operation         (cur_req.op),
    .in_rule_index        (cur_req.idx),
    .in_direction         (cur_req.dir),
    .in_protocol          (cur_req.proto),
    .in_src_address       (cur_req.src),
    .in_dst_address       (cur_req.dst),
    .in_src_prefix_mask   (cur_req.smask),
    .in_dst_prefix_mask   (cur_req.dmask),
    .in_port_a            (cur_req.pa),
    .in_port_b            (cur_req.pb),
    .in_deny_action       (cur_req.deny),
    .in_enable_bit        (cur_req.en),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_denied           (out_denied),
    .out_rule_hit         (out_rule_hit),
    .out_hit_index        (out_hit_index),
    .out_classified_count (out_classified_count),
    .out_allowed_count    (out_allowed_count),
    .out_denied_count     (out_denied_count)
  );

  // Pending requests, expected verdicts, and the rule table as the stimulus sees it.
  request_t request_queue[$];
  verdict_t verdict_queue[$];
  rule_t plan_rules[NUM_RULES];

  // Predicted state of the classifier.
  rule_t rule_table[NUM_RULES];
  logic [CNT_W-1:0] seen_count = '0;
  logic [CNT_W-1:0] pass_count = '0;
  logic [CNT_W-1:0] drop_count = '0;

  int total_requests = 0;
  int accepted_requests = 0;
  int checked_results = 0;
  int fail_count = 0;
  int cycle_count = 0;
  int n_classify = 0;
  int n_write = 0;
  int n_enable = 0;
  int n_unused = 0;
  int n_hits = 0;
  int n_denials = 0;
  bit req_taken = 1'b0;
  int burst_left = 4;
  int gap_left = 0;
  int stall_left = 0;
  logic [31:0] stall_pattern = '0;

  initial begin
    forever #2 clk = ~clk;
  end

  // Rule check: whether one enabled rule matches the packet in every field.
  function automatic logic rule_fits(rule_t r, request_t q);
    logic [PORT_W-1:0] port;
    port = q.dir ? q.pb : q.pa;
    if (!r.enable || r.dir != q.dir) return 1'b0;
    if (r.proto != PROTO_ANY && r.proto != q.proto) return 1'b0;
    if (r.src_addr != '0 && ((q.src ^ r.src_addr) & r.src_pmask) != '0) return 1'b0;
    if (r.dst_addr != '0 && ((q.dst ^ r.dst_addr) & r.dst_pmask) != '0) return 1'b0;
    return (port >= r.port_lo) && (port <= r.port_hi);
  endfunction

  // Applies one request to the predicted state and returns its verdict.
  function automatic verdict_t apply_request(request_t q);
    verdict_t v;
    v = '0;
    case (q.op)
      OP_CLASSIFY: begin
        seen_count = seen_count + 1'b1;
        for (int k = 0; k < NUM_RULES; k++) begin
          if (!v.hit && rule_fits(rule_table[k], q)) begin
            v.hit = 1'b1;
            v.slot = k[SLOT_W-1:0];
            v.denied = rule_table[k].deny;
          end
        end
        if (v.denied) drop_count = drop_count + 1'b1;
        else pass_count = pass_count + 1'b1;
      end
      OP_WRITE_RULE: begin
        if (q.idx < NUM_RULES) begin
          rule_table[q.idx] = '{src_addr: q.src, dst_addr: q.dst, src_pmask: q.smask,
                                dst_pmask: q.dmask, port_lo: q.pa, port_hi: q.pb,
                                enable: q.en, dir: q.dir, proto: q.proto, deny: q.deny};
        end
      end
      OP_SET_ENABLE: begin
        if (q.idx < NUM_RULES) rule_table[q.idx].enable = q.en;
      end
      default: begin
      end
    endcase
    v.classified = seen_count;
    v.allowed = pass_count;
    v.refused = drop_count;
    return v;
  endfunction

  function automatic request_t random_fill();
    request_t q;
    logic [7*32-1:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    q = raw[$bits(request_t)-1:0];
    return q;
  endfunction

  function automatic logic [ADDR_W-1:0] prefix_mask();
    int len;
    len = $urandom_range(0, 32);
    if (len == 0) return '0;
    return {ADDR_W{1'b1}} << (32 - len);
  endfunction

  task automatic add_write(input int idx, input logic dir, input logic [1:0] proto,
                           input logic [ADDR_W-1:0] src, input logic [ADDR_W-1:0] dst,
                           input logic [ADDR_W-1:0] smask, input logic [ADDR_W-1:0] dmask,
                           input logic [PORT_W-1:0] lo, input logic [PORT_W-1:0] hi,
                           input logic deny, input logic en);
    request_t q;
    q = random_fill();
    q.op = OP_WRITE_RULE;
    q.idx = idx[SLOT_W-1:0];
    q.dir = dir;
    q.proto = proto;
    q.src = src;
    q.dst = dst;
    q.smask = smask;
    q.dmask = dmask;
    q.pa = lo;
    q.pb = hi;
    q.deny = deny;
    q.en = en;
    plan_rules[idx] = '{src_addr: src, dst_addr: dst, src_pmask: smask, dst_pmask: dmask,
                        port_lo: lo, port_hi: hi, enable: en, dir: dir, proto: proto,
                        deny: deny};
    request_queue = {request_queue, q};
  endtask

  task automatic add_enable(input int idx, input logic en);
    request_t q;
    q = random_fill();
    q.op = OP_SET_ENABLE;
    q.idx = idx[SLOT_W-1:0];
    q.en = en;
    plan_rules[idx].enable = en;
    request_queue = {request_queue, q};
  endtask

  task automatic add_classify(input logic dir, input logic [1:0] proto,
                              input logic [ADDR_W-1:0] src, input logic [ADDR_W-1:0] dst,
                              input logic [PORT_W-1:0] pa, input logic [PORT_W-1:0] pb);
    request_t q;
    q = random_fill();
    q.op = OP_CLASSIFY;
    q.dir = dir;
    q.proto = proto;
    q.src = src;
    q.dst = dst;
    q.pa = pa;
    q.pb = pb;
    request_queue = {request_queue, q};
  endtask

  // A random rule with realistic prefixes and port ranges.
  task automatic add_random_rule();
    logic [ADDR_W-1:0] src, dst, smask, dmask;
    logic [PORT_W-1:0] lo, hi;
    int pick;
    src = ($urandom_range(0, 3) == 0) ? '0 : $urandom;
    dst = ($urandom_range(0, 3) == 0) ? '0 : $urandom;
    smask = ($urandom_range(0, 9) == 0) ? $urandom : prefix_mask();
    dmask = ($urandom_range(0, 9) == 0) ? $urandom : prefix_mask();
    lo = PORT_W'($urandom);
    pick = $urandom_range(0, 9);
    if (pick < 2) begin
      lo = '0;
      hi = '1;
    end else if (pick == 2) begin
      hi = PORT_W'(lo - $urandom_range(1, 500));
    end else if (pick == 3) begin
      hi = lo;
    end else begin
      hi = (lo > 16'hFFFF - 4000) ? 16'hFFFF : PORT_W'(lo + $urandom_range(0, 4000));
    end
    add_write($urandom_range(0, NUM_RULES - 1), 1'($urandom_range(0, 1)),
              2'($urandom_range(0, 3)), src, dst, smask, dmask, lo, hi,
              1'($urandom_range(0, 1)), $urandom_range(0, 99) < 85);
  endtask

  // A packet aimed at one planned rule, sometimes nudged just outside it.
  task automatic add_aimed_packet();
    rule_t r;
    logic dir;
    logic [1:0] proto;
    logic [ADDR_W-1:0] src, dst;
    logic [PORT_W-1:0] pa, pb, port;
    r = plan_rules[$urandom_range(0, NUM_RULES - 1)];
    dir = r.dir;
    proto = (r.proto == PROTO_ANY) ? 2'($urandom_range(0, 3)) : r.proto;
    src = (r.src_addr & r.src_pmask) | ($urandom & ~r.src_pmask);
    dst = (r.dst_addr & r.dst_pmask) | ($urandom & ~r.dst_pmask);
    port = (r.port_lo <= r.port_hi) ? PORT_W'($urandom_range(r.port_hi, r.port_lo))
                                     : PORT_W'($urandom);
    if ($urandom_range(0, 4) == 0) begin
      case ($urandom_range(0, 3))
        0: src = src ^ (32'h1 << $urandom_range(0, 31));
        1: dst = dst ^ (32'h1 << $urandom_range(0, 31));
        2: port = r.port_hi + 1'b1;
        default: dir = ~dir;
      endcase
    end
    pa = PORT_W'($urandom);
    pb = PORT_W'($urandom);
    if (dir) pb = port;
    else pa = port;
    add_classify(dir, proto, src, dst, pa, pb);
  endtask

  task automatic report_failure(input string what);
    fail_count++;
    if (fail_count <= 10) $display("MISMATCH at cycle %0d: %s", cycle_count, what);
  endtask

  // Stimulus, then wait for every verdict and a quiet tail.
  initial begin
    request_t q;
    int pick;
    for (int k = 0; k < NUM_RULES; k++) begin
      plan_rules[k] = '0;
      rule_table[k] = '0;
    end

    // Empty table: default allow, at the field extremes.
    add_classify(1'b1, PROTO_ANY, '1, '1, '1, '1);
    add_classify(1'b0, 2'd3, '0, '0, '0, '0);
    q = random_fill();
    q.op = OP_UNUSED;
    request_queue = {request_queue, q};
    // Slot 0 denies inbound tcp to one /8 on port 80; slot 1 allows all inbound.
    add_write(0, 1'b1, 2'd1, '0, 32'h0A00_0000, '1, 32'hFF00_0000, 16'd80, 16'd80,
              1'b1, 1'b1);
    add_write(1, 1'b1, PROTO_ANY, '0, '0, '0, '0, '0, '1, 1'b0, 1'b1);
    add_write(NUM_RULES - 1, 1'b0, PROTO_ANY, '1, '0, '1, '0, '0, '1, 1'b0, 1'b1);
    add_classify(1'b1, 2'd1, 32'h1234_5678, 32'h0A12_3456, 16'd9, 16'd80);
    add_classify(1'b1, 2'd2, 32'h1234_5678, 32'h0A12_3456, 16'd9, 16'd80);
    add_classify(1'b1, 2'd1, 32'h1234_5678, 32'h0A12_3456, 16'd80, 16'd81);
    add_classify(1'b1, PROTO_ANY, '1, 32'h0A00_0001, '1, 16'd80);
    add_classify(1'b0, PROTO_ANY, '1, '1, '1, '0);
    add_classify(1'b0, 2'd2, 32'hFFFF_FFFE, '1, '1, '0);
    // Disabling slot 1 leaves non-tcp inbound traffic to the default allow.
    add_enable(1, 1'b0);
    add_classify(1'b1, 2'd2, '0, 32'h0A00_0000, '0, '0);
    // An inverted port range matches nothing.
    add_write(2, 1'b1, PROTO_ANY, '0, '0, '0, '0, 16'd100, 16'd50, 1'b1, 1'b1);
    add_classify(1'b1, 2'd3, '1, '1, '0, 16'd75);
    add_classify(1'b1, 2'd3, '1, '1, '0, 16'd100);
    // Toggling the enable keeps the rest of slot 0.
    add_enable(0, 1'b0);
    add_classify(1'b1, 2'd1, '0, 32'h0AFF_FFFF, '0, 16'd80);
    add_enable(0, 1'b1);
    add_classify(1'b1, 2'd1, '0, 32'h0AFF_FFFF, '0, 16'd80);
    // A disabled rule, then a nonzero address under a zero mask.
    add_write(3, 1'b0, PROTO_ANY, '0, '0, '0, '0, '0, '1, 1'b1, 1'b0);
    add_classify(1'b0, 2'd1, 32'h0000_0001, '0, 16'd1, '0);
    add_write(4, 1'b0, 2'd3, 32'hDEAD_BEEF, '1, '0, '0, '0, '1, 1'b1, 1'b1);
    add_classify(1'b0, 2'd3, 32'h0000_0001, 32'h8000_0000, 16'd7, '1);

    // Random traffic: mostly packets aimed at planned rules, with table churn.
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        add_random_rule();
      end else if (pick < 22) begin
        add_enable($urandom_range(0, NUM_RULES - 1), 1'($urandom_range(0, 1)));
      end else if (pick < 25) begin
        q = random_fill();
        q.op = OP_UNUSED;
        request_queue = {request_queue, q};
      end else if (pick < 75) begin
        add_aimed_packet();
      end else begin
        add_classify(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)), $urandom,
                     $urandom, PORT_W'($urandom), PORT_W'($urandom));
      end
    end
    total_requests = request_queue.size();

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (accepted_requests < total_requests || verdict_queue.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d requests: %0d classify, %0d rule writes, %0d enable updates, %0d unused.",
             accepted_requests, n_classify, n_write, n_enable, n_unused);
    $display("Checked %0d results: %0d rule hits, %0d denials, %0d mismatches.",
             checked_results, n_hits, n_denials, fail_count);
    if (fail_count == 0) begin
      $display("first_match_packet_rule_classifier_top regression: pass");
    end else begin
      $display("first_match_packet_rule_classifier_top regression: fail");
    end
    $finish;
  end

  // Sender: bursts of requests with random gaps; the payload holds until accepted.
  always @(negedge clk) begin
    if (rst_n && (!in_valid || req_taken)) begin
      req_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (request_queue.size() > 0) begin
        cur_req <= request_queue[0];
        request_queue.delete(0);
        in_valid <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: stall on a random pattern that is redrawn whenever its countdown runs out.
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_left = $urandom_range(16, 96);
      case ($urandom_range(0, 3))
        0: stall_pattern = '0;
        1: stall_pattern = $urandom;
        2: stall_pattern = $urandom & $urandom;
        default: stall_pattern = 32'hFFFF_FF00;
      endcase
    end
    stall_left--;
    out_stall <= stall_pattern[5'(stall_left % 32)];
  end

  // Acceptance of requests and checking of results.
  always @(posedge clk) begin
    verdict_t want;
    verdict_t got;
    if (rst_n && in_valid && !in_stall && !req_taken) begin
      req_taken = 1'b1;
      accepted_requests++;
      want = apply_request(cur_req);
      verdict_queue = {verdict_queue, want};
      case (cur_req.op)
        OP_CLASSIFY: n_classify++;
        OP_WRITE_RULE: n_write++;
        OP_SET_ENABLE: n_enable++;
        default: n_unused++;
      endcase
      n_hits += want.hit;
      n_denials += want.denied;
    end
    if (rst_n && out_valid && !out_stall) begin
      got = '{denied: out_denied, hit: out_rule_hit, slot: out_hit_index,
              classified: out_classified_count, allowed: out_allowed_count,
              refused: out_denied_count};
      if (verdict_queue.size() == 0) begin
        report_failure($sformatf("result with no request outstanding: denied=%0b hit=%0b",
                                 got.denied, got.hit));
      end else begin
        want = verdict_queue[0];
        verdict_queue.delete(0);
        checked_results++;
        if (got != want) begin
          report_failure($sformatf(
            "expected denied=%0b hit=%0b index=%0d counts=%0d/%0d/%0d, got %0b %0b %0d %0d/%0d/%0d",
            want.denied, want.hit, want.slot, want.classified, want.allowed, want.refused,
            got.denied, got.hit, got.slot, got.classified, got.allowed, got.refused));
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d of %0d requests accepted.",
               cycle_count, accepted_requests, total_requests);
      $display("first_match_packet_rule_classifier_top regression: fail");
      $finish;
    end
  end

endmodule
